FILE: design/aes128_block_encrypt_macros.svh
// assertion macros for the aes block
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

// a condition implies another in the same cycle
`define AES_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// a condition implies another in the next cycle
`define AES_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

FILE: design/aes_pkg.sv
package aes_pkg;

   localparam int NumRounds = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic      valid;
      block_type data;
   } stage_type;

   localparam byte_type SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam byte_type RCON [10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // byte i of a block, byte 0 in the top bits
   function automatic byte_type get_byte(block_type b, int i);
      return b[127-8*i -: 8];
   endfunction

   function automatic byte_type xtime(byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // next round key from the previous one, rc is the round constant
   function automatic block_type next_key(block_type k, byte_type rc);
      logic [31:0] w [4];
      logic [31:0] t;
      block_type   r;
      for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
      t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
      w[0] = w[0] ^ t;
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      w[3] = w[3] ^ w[2];
      r = {w[0], w[1], w[2], w[3]};
      return r;
   endfunction

   // subbytes, shiftrows and optional mixcolumns
   function automatic block_type round_fn(block_type s, logic mix);
      byte_type  t [16];
      byte_type  a0, a1, a2, a3, all;
      block_type r;
      for (int c = 0; c < 4; c++)
         for (int q = 0; q < 4; q++)
            t[4*c+q] = SBOX[get_byte(s, (4*((c+q)%4)+q))];
      if (mix)
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
      return r;
   endfunction

endpackage

FILE: design/aes_round_cell.sv
module aes_round_cell
   import aes_pkg::*;
#(
   parameter logic [7:0] RoundConst = 8'h01,
   parameter bit         MixEnable  = 1'b1
) (
   input  logic      clock,
   input  logic      reset,
   input  stage_type prev_stage,
   input  block_type prev_key,
   output stage_type next_stage,
   output block_type next_key_out
);

   stage_type stage_ff, stage_in;
   block_type key_ff, key_in;

   // key travels with its block so a key change never mixes schedules
   always_comb begin
      key_in         = next_key(prev_key, RoundConst);
      stage_in.valid = prev_stage.valid;
      stage_in.data  = round_fn(prev_stage.data, MixEnable) ^ key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.data <= stage_in.data;
      key_ff        <= key_in;
   end

   assign next_stage   = stage_ff;
   assign next_key_out = key_ff;

endmodule

FILE: design/aes128_block_encrypt.sv
// aes-128 encryption of one 128-bit block per item. an item is taken whenever
// start is high and busy is low; busy is always low, so a new item may enter
// every cycle. the result appears on rsp_cipher_high/low with rsp_valid high
// for one cycle, after passing through one input cell doing the initial key
// addition, then ten round cells. results can not be held off by the
// receiver. each cell expands its own round key from the key carried
// alongside the block, so key writes affect only later items.
`include "aes128_block_encrypt_macros.svh"

module aes128_block_encrypt
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);

   // key registers
   logic [63:0] key_high_ff, key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // input cell: initial key addition
   stage_type stage [NumRounds+1];
   block_type rkey  [NumRounds+1];
   stage_type stage0_ff;
   block_type rkey0_ff;
   block_type key_cur;

   assign key_cur = {key_high_ff, key_low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage0_ff.valid <= 1'b0;
      end else begin
         stage0_ff.valid <= start && !busy;
      end
      stage0_ff.data <= {req_plain_high, req_plain_low} ^ key_cur;
      rkey0_ff       <= key_cur;
   end

   assign stage[0] = stage0_ff;
   assign rkey[0]  = rkey0_ff;

   // chain of round cells, last one skips mixcolumns
   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      aes_round_cell #(
         .RoundConst (RCON[g]),
         .MixEnable  (g != NumRounds - 1)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .prev_stage   (stage[g]),
         .prev_key     (rkey[g]),
         .next_stage   (stage[g+1]),
         .next_key_out (rkey[g+1])
      );
   end

   assign rsp_valid       = stage[NumRounds].valid;
   assign rsp_cipher_high = stage[NumRounds].data[127:64];
   assign rsp_cipher_low  = stage[NumRounds].data[63:0];

   // an accepted item reaches the first round cell next cycle
   `AES_ASSERT_NEXT(a_enter, clock, reset, start && !busy, stage0_ff.valid)
   // no item enters, nothing in the first cell
   `AES_ASSERT_NEXT(a_idle, clock, reset, !start, !stage0_ff.valid)
   // neither the csr port nor the start port ever stalls
   `AES_ASSERT_IMPLY(a_ready, clock, reset, 1'b1, csr_ready && !busy)

endmodule
